// ===== sv/sc2esc_pkg.sv =====
// ----------------------------------------------------------------------------
// sc2esc_pkg
// Types, constants and escape sequence tables for the scancode translator.
// ----------------------------------------------------------------------------
package sc2esc_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned SeqMax  = 5;
    localparam int unsigned SeqIdxW = 5;
    localparam int unsigned CntW    = 3;

    localparam logic [ByteW-1:0] ScPrefix   = 8'hE0;
    localparam logic [ByteW-1:0] ScAltPress = 8'h38;
    localparam logic [ByteW-1:0] ScAltRel   = 8'hB8;
    localparam logic [ByteW-1:0] ScVirtLo   = 8'h60;
    localparam logic [ByteW-1:0] ScVirtHi   = 8'h6F;
    localparam logic [ByteW-1:0] ScVirtLast = 8'h69;
    localparam logic [ByteW-1:0] ScF1       = 8'h3B;
    localparam logic [ByteW-1:0] ScF10      = 8'h44;
    localparam logic [ByteW-1:0] ScF11      = 8'h57;
    localparam logic [ByteW-1:0] ScF12      = 8'h58;
    localparam logic [ByteW-1:0] EscByte    = 8'h1B;

    // Sequence indexes for the function keys.
    localparam logic [SeqIdxW-1:0] IdxF1  = 5'd10;
    localparam logic [SeqIdxW-1:0] IdxF11 = 5'd20;
    localparam logic [SeqIdxW-1:0] IdxF12 = 5'd21;

    // One translated item waiting for or in the emitter.
    typedef struct packed {
        logic               fwd;
        logic [ByteW-1:0]   raw;
        logic [SeqIdxW-1:0] idx;
    } job_t;

    // Navigation key lookup after an extended prefix.
    function automatic logic nav_hit(input logic [ByteW-1:0] sc);
        case (sc)
            8'h48, 8'h50, 8'h4D, 8'h4B, 8'h47,
            8'h4F, 8'h49, 8'h51, 8'h52, 8'h53: nav_hit = 1'b1;
            default:                           nav_hit = 1'b0;
        endcase
    endfunction

    function automatic logic [SeqIdxW-1:0] nav_idx(input logic [ByteW-1:0] sc);
        case (sc)
            8'h48:   nav_idx = 5'd0;
            8'h50:   nav_idx = 5'd1;
            8'h4D:   nav_idx = 5'd2;
            8'h4B:   nav_idx = 5'd3;
            8'h47:   nav_idx = 5'd4;
            8'h4F:   nav_idx = 5'd5;
            8'h49:   nav_idx = 5'd6;
            8'h51:   nav_idx = 5'd7;
            8'h52:   nav_idx = 5'd8;
            8'h53:   nav_idx = 5'd9;
            default: nav_idx = 5'd0;
        endcase
    endfunction

    // Number of bytes in each escape sequence.
    function automatic logic [CntW-1:0] seq_len(input logic [SeqIdxW-1:0] idx);
        case (idx)
            5'd6, 5'd7, 5'd8, 5'd9:                 seq_len = 3'd4;
            5'd14, 5'd15, 5'd16, 5'd17,
            5'd18, 5'd19, 5'd20, 5'd21:             seq_len = 3'd5;
            default:                                seq_len = 3'd3;
        endcase
    endfunction

    // Escape sequence bytes, first byte in element zero.
    function automatic logic [SeqMax-1:0][ByteW-1:0] seq_bytes(
        input logic [SeqIdxW-1:0] idx
    );
        case (idx)
            5'd0:    seq_bytes = {8'h00, 8'h00, "A", "[", EscByte};
            5'd1:    seq_bytes = {8'h00, 8'h00, "B", "[", EscByte};
            5'd2:    seq_bytes = {8'h00, 8'h00, "C", "[", EscByte};
            5'd3:    seq_bytes = {8'h00, 8'h00, "D", "[", EscByte};
            5'd4:    seq_bytes = {8'h00, 8'h00, "H", "[", EscByte};
            5'd5:    seq_bytes = {8'h00, 8'h00, "F", "[", EscByte};
            5'd6:    seq_bytes = {8'h00, "~", "5", "[", EscByte};
            5'd7:    seq_bytes = {8'h00, "~", "6", "[", EscByte};
            5'd8:    seq_bytes = {8'h00, "~", "2", "[", EscByte};
            5'd9:    seq_bytes = {8'h00, "~", "3", "[", EscByte};
            5'd10:   seq_bytes = {8'h00, 8'h00, "P", "O", EscByte};
            5'd11:   seq_bytes = {8'h00, 8'h00, "Q", "O", EscByte};
            5'd12:   seq_bytes = {8'h00, 8'h00, "R", "O", EscByte};
            5'd13:   seq_bytes = {8'h00, 8'h00, "S", "O", EscByte};
            5'd14:   seq_bytes = {"~", "5", "1", "[", EscByte};
            5'd15:   seq_bytes = {"~", "7", "1", "[", EscByte};
            5'd16:   seq_bytes = {"~", "8", "1", "[", EscByte};
            5'd17:   seq_bytes = {"~", "9", "1", "[", EscByte};
            5'd18:   seq_bytes = {"~", "0", "2", "[", EscByte};
            5'd19:   seq_bytes = {"~", "1", "2", "[", EscByte};
            5'd20:   seq_bytes = {"~", "3", "2", "[", EscByte};
            5'd21:   seq_bytes = {"~", "4", "2", "[", EscByte};
            default: seq_bytes = '0;
        endcase
    endfunction

endpackage

// ===== sv/scancode_to_escape_sequence.sv =====
// ----------------------------------------------------------------------------
// scancode_to_escape_sequence
// Turns PS/2 set 1 scancodes into ANSI escape bytes or forwarded raw codes.
// ----------------------------------------------------------------------------
// The first result byte is valid once the item has passed the input stage and
// been loaded into the byte emitter stage. The emitter gives one result byte per
// cycle while m_tready is held high: one byte for a forwarded code and 3 to 5
// bytes for an escape sequence. Items that give no result are taken without
// entering either stage. Reset clears the prefix flag and both item stages; no
// result is pending after reset.
module scancode_to_escape_sequence (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] scancode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] is_forwarded
    output logic       m_tlast
);

    logic                          prefix_reg, prefix_next;
    logic                          a_valid_reg, a_valid_next;
    sc2esc_pkg::job_t              a_job_reg, dec_job;
    logic                          dec_emit;
    logic                          b_valid_reg, b_valid_next;
    sc2esc_pkg::job_t              b_job_reg;
    logic [sc2esc_pkg::CntW-1:0]   b_cnt_reg, b_cnt_next, b_len;
    logic [sc2esc_pkg::SeqMax-1:0][sc2esc_pkg::ByteW-1:0] b_seq;
    logic                          s_take, a_load, b_load, b_step, b_done;

    // Decode the incoming scancode into a job and the next prefix flag.
    always_comb begin
        dec_emit        = 1'b0;
        dec_job.fwd     = 1'b0;
        dec_job.raw     = s_tdata;
        dec_job.idx     = '0;
        prefix_next     = prefix_reg;
        if (s_tdata inside {sc2esc_pkg::ScAltPress, sc2esc_pkg::ScAltRel}) begin
            dec_emit = 1'b0;
        end else if (s_tdata == sc2esc_pkg::ScPrefix) begin
            prefix_next = 1'b1;
        end else if (prefix_reg) begin
            prefix_next = 1'b0;
            dec_emit    = !s_tdata[7] && sc2esc_pkg::nav_hit(s_tdata);
            dec_job.idx = sc2esc_pkg::nav_idx(s_tdata);
        end else if (s_tdata inside {[sc2esc_pkg::ScVirtLo:sc2esc_pkg::ScVirtHi]}) begin
            dec_emit    = (s_tdata <= sc2esc_pkg::ScVirtLast);
            dec_job.idx = {1'b0, s_tdata[3:0]};
        end else if (s_tdata inside {[sc2esc_pkg::ScF1:sc2esc_pkg::ScF10]}) begin
            dec_emit    = 1'b1;
            dec_job.idx = sc2esc_pkg::IdxF1
                        + sc2esc_pkg::SeqIdxW'(s_tdata - sc2esc_pkg::ScF1);
        end else if (s_tdata == sc2esc_pkg::ScF11) begin
            dec_emit    = 1'b1;
            dec_job.idx = sc2esc_pkg::IdxF11;
        end else if (s_tdata == sc2esc_pkg::ScF12) begin
            dec_emit    = 1'b1;
            dec_job.idx = sc2esc_pkg::IdxF12;
        end else begin
            dec_emit    = 1'b1;
            dec_job.fwd = 1'b1;
        end
    end

    // Emitter view of the current job.
    assign b_len    = sc2esc_pkg::seq_len(b_job_reg.idx);
    assign b_seq    = sc2esc_pkg::seq_bytes(b_job_reg.idx);
    assign m_tvalid = b_valid_reg;
    assign m_tuser  = b_job_reg.fwd;
    assign m_tdata  = b_job_reg.fwd ? b_job_reg.raw : b_seq[b_cnt_reg];
    assign m_tlast  = b_job_reg.fwd || (b_cnt_reg == b_len - 3'd1);

    // Handshake and stage movement; the input stage frees up in the same
    // cycle that its job moves on to the emitter.
    assign s_tready = !a_valid_reg || b_load;
    assign s_take   = s_tvalid && s_tready;
    assign a_load   = s_take && dec_emit;
    assign b_step   = b_valid_reg && m_tready;
    assign b_done   = b_step && m_tlast;
    assign b_load   = a_valid_reg && (!b_valid_reg || b_done);

    // Next values of the stage control.
    always_comb begin
        a_valid_next = a_valid_reg;
        if (a_load) begin
            a_valid_next = 1'b1;
        end else if (b_load) begin
            a_valid_next = 1'b0;
        end
        b_valid_next = b_valid_reg;
        b_cnt_next   = b_cnt_reg;
        if (b_load) begin
            b_valid_next = 1'b1;
            b_cnt_next   = '0;
        end else if (b_done) begin
            b_valid_next = 1'b0;
        end else if (b_step) begin
            b_cnt_next = b_cnt_reg + 3'd1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg  <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            b_cnt_reg   <= '0;
        end else begin
            if (s_take) begin
                prefix_reg <= prefix_next;
            end
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            b_cnt_reg   <= b_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_job_reg <= dec_job;
        end
        if (b_load) begin
            b_job_reg <= a_job_reg;
        end
    end

    // A forwarded code is always a single, final byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("forwarded byte not marked last");

    // Every escape sequence starts with the escape byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser && b_cnt_reg == '0 |-> m_tdata == sc2esc_pkg::EscByte)
        else $error("escape sequence does not start with ESC");

    // The byte counter never runs past the sequence length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !b_job_reg.fwd |-> b_cnt_reg < b_len)
        else $error("emitter counter out of range");

    // A taken prefix byte leaves the flag set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata == sc2esc_pkg::ScPrefix |=> prefix_reg)
        else $error("prefix flag not set after prefix byte");

endmodule

// ===== sim/tb_scancode_to_escape_sequence.sv =====
// ----------------------------------------------------------------------------
// tb_scancode_to_escape_sequence
// Self-checking bench for the scancode to escape sequence translator. Sends
// directed scancodes covering prefix, Alt, release, virtual and function key
// cases, then a long run of mostly well-formed random key traffic. Output bytes
// are checked against an in-bench translator, with random gaps on both
// streams and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_scancode_to_escape_sequence;

    timeunit 1ns;
    timeprecision 1ps;

    // Navigation keys after an extended prefix.
    localparam logic [7:0] KeyUp     = 8'h48;
    localparam logic [7:0] KeyDown   = 8'h50;
    localparam logic [7:0] KeyRight  = 8'h4D;
    localparam logic [7:0] KeyLeft   = 8'h4B;
    localparam logic [7:0] KeyHome   = 8'h47;
    localparam logic [7:0] KeyEnd    = 8'h4F;
    localparam logic [7:0] KeyPgUp   = 8'h49;
    localparam logic [7:0] KeyPgDn   = 8'h51;
    localparam logic [7:0] KeyIns    = 8'h52;
    localparam logic [7:0] KeyDel    = 8'h53;
    localparam logic [7:0] RelBit    = 8'h80;
    localparam logic [7:0] KeyA      = 8'h1E;
    localparam logic [7:0] KeyNumLk  = 8'h45;

    localparam int unsigned NumCodes   = 270;
    localparam int unsigned MaxWait    = 16;
    localparam int unsigned HoldAt     = 60;
    localparam int unsigned HoldCycles = 300;
    localparam int unsigned DrainWait  = 20;
    localparam int unsigned CycleLimit = 200000;

    typedef struct packed {
        logic [7:0] data;
        logic       fwd;
        logic       last;
    } term_byte_t;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    logic [7:0]  pending_codes[$];
    term_byte_t  expected_term_bytes[$];
    logic        ext_prefix_seen = 1'b0;
    int unsigned codes_taken     = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;
    int unsigned tx_gap          = 0;
    int unsigned rx_stall        = 0;
    int unsigned hold_left       = 0;
    logic        hold_done       = 1'b0;
    logic        tx_calm         = 1'b0;
    logic        rx_calm         = 1'b0;

    scancode_to_escape_sequence DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Escape text for each sequence slot: ten navigation keys, then F1 to F12.
    function automatic string escape_text(input int slot);
        case (slot)
            0:       return "\033[A";
            1:       return "\033[B";
            2:       return "\033[C";
            3:       return "\033[D";
            4:       return "\033[H";
            5:       return "\033[F";
            6:       return "\033[5~";
            7:       return "\033[6~";
            8:       return "\033[2~";
            9:       return "\033[3~";
            10:      return "\033OP";
            11:      return "\033OQ";
            12:      return "\033OR";
            13:      return "\033OS";
            14:      return "\033[15~";
            15:      return "\033[17~";
            16:      return "\033[18~";
            17:      return "\033[19~";
            18:      return "\033[20~";
            19:      return "\033[21~";
            20:      return "\033[23~";
            21:      return "\033[24~";
            default: return "";
        endcase
    endfunction

    // Slot of a navigation key, or -1 when the code is not one.
    function automatic int nav_slot(input logic [7:0] sc);
        case (sc)
            KeyUp:    return 0;
            KeyDown:  return 1;
            KeyRight: return 2;
            KeyLeft:  return 3;
            KeyHome:  return 4;
            KeyEnd:   return 5;
            KeyPgUp:  return 6;
            KeyPgDn:  return 7;
            KeyIns:   return 8;
            KeyDel:   return 9;
            default:  return -1;
        endcase
    endfunction

    function automatic logic [7:0] nav_code(input int unsigned n);
        case (n)
            0:       return KeyUp;
            1:       return KeyDown;
            2:       return KeyRight;
            3:       return KeyLeft;
            4:       return KeyHome;
            5:       return KeyEnd;
            6:       return KeyPgUp;
            7:       return KeyPgDn;
            8:       return KeyIns;
            default: return KeyDel;
        endcase
    endfunction

    // Slot of a function key, or -1.
    function automatic int fkey_slot(input logic [7:0] sc);
        if (sc inside {[sc2esc_pkg::ScF1:sc2esc_pkg::ScF10]})
            return 10 + int'(sc - sc2esc_pkg::ScF1);
        if (sc == sc2esc_pkg::ScF11) return 20;
        if (sc == sc2esc_pkg::ScF12) return 21;
        return -1;
    endfunction

    // Queue the bytes of one escape sequence, last flag on the final byte.
    task automatic push_escape(input int slot);
        string      text;
        term_byte_t tb;
        text = escape_text(slot);
        for (int k = 0; k < text.len(); k++) begin
            tb.data = text[k];
            tb.fwd  = 1'b0;
            tb.last = (k == text.len() - 1);
            expected_term_bytes.push_back(tb);
        end
    endtask

    // Translate one accepted scancode and queue the bytes it should produce.
    task automatic translate_scancode(input logic [7:0] sc);
        term_byte_t tb;
        if (sc inside {sc2esc_pkg::ScAltPress, sc2esc_pkg::ScAltRel}) return;
        if (sc == sc2esc_pkg::ScPrefix) begin
            ext_prefix_seen = 1'b1;
            return;
        end
        if (ext_prefix_seen) begin
            ext_prefix_seen = 1'b0;
            if ((sc & RelBit) == 8'h00 && nav_slot(sc) >= 0) push_escape(nav_slot(sc));
            return;
        end
        if (sc inside {[sc2esc_pkg::ScVirtLo:sc2esc_pkg::ScVirtHi]}) begin
            if (sc <= sc2esc_pkg::ScVirtLast) push_escape(int'(sc - sc2esc_pkg::ScVirtLo));
            return;
        end
        if (fkey_slot(sc) >= 0) begin
            push_escape(fkey_slot(sc));
            return;
        end
        tb.data = sc;
        tb.fwd  = 1'b1;
        tb.last = 1'b1;
        expected_term_bytes.push_back(tb);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Gap or stall length for one item; calm stretches have none.
    function automatic int unsigned draw_wait(input logic calm);
        if (calm) return 0;
        return $urandom_range(0, MaxWait);
    endfunction

    // Input driver: offers pending scancodes with random gaps between them.
    always @(posedge aclk) begin : tx_side
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                translate_scancode(s_tdata);
                codes_taken <= codes_taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    s_tvalid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end else if (pending_codes.size() != 0) begin
                    s_tdata  <= pending_codes.pop_front();
                    s_tvalid <= 1'b1;
                    tx_gap   <= draw_wait(tx_calm);
                    if ($urandom_range(0, 31) == 0) tx_calm <= !tx_calm;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long output hold-off partway through, so the block backs up.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!hold_done && codes_taken >= HoldAt) begin
                hold_left <= HoldCycles;
                hold_done <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // Output monitor: checks each byte against the oldest expectation.
    always @(posedge aclk) begin : rx_side
        term_byte_t  want;
        int unsigned nxt;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else if (m_tvalid && m_tready) begin
            if (expected_term_bytes.size() == 0) begin
                report_mismatch("unexpected output byte", m_tdata, 0);
            end else begin
                want = expected_term_bytes.pop_front();
                if (m_tdata !== want.data) report_mismatch("out_byte", m_tdata, want.data);
                if (m_tuser !== want.fwd) report_mismatch("is_forwarded", m_tuser, want.fwd);
                if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
            end
            nxt = draw_wait(rx_calm);
            rx_stall <= nxt;
            m_tready <= (nxt == 0) && (hold_left == 0);
            if ($urandom_range(0, 31) == 0) rx_calm <= !rx_calm;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
        end else if (rx_stall != 0) begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        int unsigned pick;
        int unsigned r;
        int unsigned fk;

        // Directed: field extremes, Alt with and without prefix, repeated
        // prefix, release and unknown code after prefix, virtual and F keys.
        pending_codes.push_back(8'h00);
        pending_codes.push_back(8'hFF);
        pending_codes.push_back(sc2esc_pkg::ScAltPress);
        pending_codes.push_back(sc2esc_pkg::ScAltRel);
        pending_codes.push_back(sc2esc_pkg::ScPrefix);
        pending_codes.push_back(sc2esc_pkg::ScAltPress);
        pending_codes.push_back(KeyUp);
        pending_codes.push_back(sc2esc_pkg::ScPrefix);
        pending_codes.push_back(sc2esc_pkg::ScPrefix);
        pending_codes.push_back(KeyDown);
        pending_codes.push_back(sc2esc_pkg::ScPrefix);
        pending_codes.push_back(KeyUp | RelBit);
        pending_codes.push_back(sc2esc_pkg::ScPrefix);
        pending_codes.push_back(KeyA);
        pending_codes.push_back(sc2esc_pkg::ScPrefix);
        pending_codes.push_back(KeyDel);
        pending_codes.push_back(sc2esc_pkg::ScVirtLo);
        pending_codes.push_back(sc2esc_pkg::ScVirtLast);
        pending_codes.push_back(sc2esc_pkg::ScVirtLast + 8'h01);
        pending_codes.push_back(sc2esc_pkg::ScVirtHi);
        pending_codes.push_back(sc2esc_pkg::ScF1);
        pending_codes.push_back(sc2esc_pkg::ScF10);
        pending_codes.push_back(sc2esc_pkg::ScF11);
        pending_codes.push_back(sc2esc_pkg::ScF12);
        pending_codes.push_back(KeyNumLk);

        // Random: mostly prefixed navigation, virtual and function keys.
        while (pending_codes.size() < NumCodes) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                pending_codes.push_back(sc2esc_pkg::ScPrefix);
                if ($urandom_range(0, 5) == 0)
                    pending_codes.push_back($urandom_range(0, 1) ?
                                            sc2esc_pkg::ScAltPress : sc2esc_pkg::ScAltRel);
                if ($urandom_range(0, 7) == 0) pending_codes.push_back(sc2esc_pkg::ScPrefix);
                r = $urandom_range(0, 9);
                if (r < 7)
                    pending_codes.push_back(nav_code($urandom_range(0, 9)));
                else if (r == 7)
                    pending_codes.push_back(nav_code($urandom_range(0, 9)) | RelBit);
                else
                    pending_codes.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 50) begin
                pending_codes.push_back(sc2esc_pkg::ScVirtLo + 8'($urandom_range(0, 15)));
            end else if (pick < 62) begin
                fk = $urandom_range(0, 11);
                if (fk < 10) pending_codes.push_back(sc2esc_pkg::ScF1 + 8'(fk));
                else if (fk == 10) pending_codes.push_back(sc2esc_pkg::ScF11);
                else pending_codes.push_back(sc2esc_pkg::ScF12);
            end else if (pick < 67) begin
                pending_codes.push_back($urandom_range(0, 1) ?
                                        sc2esc_pkg::ScAltPress : sc2esc_pkg::ScAltRel);
            end else begin
                pending_codes.push_back(8'($urandom_range(0, 255)));
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_codes.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_term_bytes.size() != 0) @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
